FILE: sv/uas_pkg.sv
`default_nettype none

package uas_pkg;

   localparam int MAX_CELLS_DEF = 16;
   localparam int RESULT_CAP    = 16;
   localparam int SLOT_W        = 5;
   localparam int CELLS_MIN     = 2;
   localparam int CSR_ADDR_W    = 3;
   localparam int CSR_DATA_W    = 32;
   localparam int CELLS_W       = 5;
   localparam int PROD_W        = 33;
   localparam int ROUND_HALF    = 16384;
   localparam int FRAC_BITS     = 15;

   localparam logic [CELLS_W-1:0] CELLS_RESET = 5'd16;
   localparam logic REG_CELLS_IN_USE = 1'b0;

   typedef struct packed {
      logic signed [15:0] courant;
      logic [15:0]        start_value;
      logic [15:0]        end_value;
   } req_payload_type;

   typedef struct packed {
      logic [3:0]  cell_index;
      logic [15:0] cell_value;
      logic        last_cell;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_ISSUE = 3'b010,
      ST_DRAIN = 3'b100
   } state_type;

   typedef struct packed {
      logic              load;
      logic              issue;
      logic [SLOT_W-1:0] slot;
      logic              emit;
      logic              final_cell;
   } cmd_type;

   typedef struct packed {
      logic busy;
      logic pos;
      logic adv;
   } stat_type;

endpackage

`default_nettype wire

FILE: sv/uas_ctrl.sv
`default_nettype none

module uas_ctrl
   import uas_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [SLOT_W-1:0] n_cells,
   input  wire stat_type          stat,
   output cmd_type                cmd
);

   state_type         state_ff, state_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [SLOT_W-1:0] n_ff, n_in;

   always_comb begin
      state_in       = state_ff;
      slot_in        = slot_ff;
      n_in           = n_ff;
      cmd.load       = 1'b0;
      cmd.issue      = 1'b0;
      cmd.slot       = slot_ff;
      cmd.emit       = stat.pos ? (slot_ff < n_ff) : (slot_ff != '0);
      cmd.final_cell = stat.pos ? (slot_ff == n_ff - SLOT_W'(1)) : (slot_ff == n_ff);
      req_stall      = (state_ff != ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               slot_in  = '0;
               n_in     = n_cells;
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            cmd.issue = 1'b1;
            // one slot more than cells: the trailing neighbor or the end inflow
            if (stat.adv) begin
               if (slot_ff == n_ff) begin
                  state_in = ST_DRAIN;
               end else begin
                  slot_in = slot_ff + SLOT_W'(1);
               end
            end
         end
         ST_DRAIN: begin
            if (!stat.busy) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         slot_ff  <= '0;
         n_ff     <= SLOT_W'(CELLS_MIN);
      end else begin
         state_ff <= state_in;
         slot_ff  <= slot_in;
         n_ff     <= n_in;
      end
   end

endmodule

`default_nettype wire

FILE: sv/uas_dpath.sv
`default_nettype none

module uas_dpath
   import uas_pkg::*;
#(
   parameter int MAX_CELLS = MAX_CELLS_DEF
)
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire req_payload_type req_payload,
   input  wire cmd_type         cmd,
   output stat_type             stat,
   input  wire logic            rsp_stall,
   output logic                 rsp_valid,
   output rsp_payload_type      rsp_payload
);

   localparam int LINE_LIMIT = (MAX_CELLS > RESULT_CAP) ? RESULT_CAP : MAX_CELLS;
   localparam int ADDR_W     = (LINE_LIMIT > 1) ? $clog2(LINE_LIMIT) : 1;

   logic [15:0]           cell_mem_ff [LINE_LIMIT];
   logic [LINE_LIMIT-1:0] vld_ff;

   logic signed [15:0] courant_ff;
   logic [15:0]        start_ff;
   logic [15:0]        end_ff;

   logic              en;
   logic              pos;

   // read stage
   logic              s1_valid_ff;
   logic [SLOT_W-1:0] s1_slot_ff;
   logic              s1_emit_ff;
   logic              s1_final_ff;
   logic [15:0]       rd_ff;
   logic [15:0]       prev_ff;

   // multiply stage
   logic                     s2_valid_ff;
   logic [SLOT_W-1:0]        s2_idx_ff;
   logic                     s2_last_ff;
   logic                     s2_bnd_ff;
   logic [15:0]              s2_bval_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic [15:0]              base_ff;

   logic                rsp_valid_ff;
   rsp_payload_type     rsp_payload_ff;

   logic [ADDR_W-1:0]        rd_addr;
   logic [ADDR_W-1:0]        wr_addr;
   logic signed [16:0]       diff;
   logic [SLOT_W-1:0]        s1_idx;
   logic                     s1_bnd;
   logic signed [PROD_W:0]   rounded;
   logic signed [PROD_W:0]   term;
   logic signed [PROD_W+1:0] res;
   logic [15:0]              new_value;

   assign en  = !rsp_valid_ff || !rsp_stall;
   assign pos = (courant_ff > 16'sd0);

   assign stat.busy = s1_valid_ff || s2_valid_ff;
   assign stat.pos  = pos;
   assign stat.adv  = en;

   assign rd_addr = cmd.slot[ADDR_W-1:0];
   assign wr_addr = s2_idx_ff[ADDR_W-1:0];

   // rd_ff holds old[j], prev_ff old[j-1]; both directions use this difference
   assign diff   = $signed({1'b0, rd_ff}) - $signed({1'b0, prev_ff});
   assign s1_idx = pos ? s1_slot_ff : (s1_slot_ff - SLOT_W'(1));
   assign s1_bnd = pos ? (s1_slot_ff == '0) : s1_final_ff;

   assign rounded = (PROD_W + 1)'(prod_ff) + (PROD_W + 1)'(ROUND_HALF);
   assign term    = rounded >>> FRAC_BITS;
   assign res     = $signed({{(PROD_W - 14){1'b0}}, base_ff}) - (PROD_W + 2)'(term);

   always_comb begin
      if (s2_bnd_ff) begin
         new_value = s2_bval_ff;
      end else if (res < 0) begin
         new_value = '0;
      end else if (res > (PROD_W + 2)'(65535)) begin
         new_value = 16'hFFFF;
      end else begin
         new_value = res[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         courant_ff <= req_payload.courant;
         start_ff   <= req_payload.start_value;
         end_ff     <= req_payload.end_value;
      end
   end

   always_ff @(posedge clock) begin
      if (en && s2_valid_ff) begin
         cell_mem_ff[wr_addr] <= new_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en && s2_valid_ff) begin
         vld_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rd_ff       <= vld_ff[rd_addr] ? cell_mem_ff[rd_addr] : 16'h0000;
         s1_slot_ff  <= cmd.slot;
         s1_emit_ff  <= cmd.emit;
         s1_final_ff <= cmd.final_cell;
         if (s1_valid_ff) begin
            prev_ff <= rd_ff;
         end
         s2_idx_ff  <= s1_idx;
         s2_last_ff <= s1_final_ff;
         s2_bnd_ff  <= s1_bnd;
         s2_bval_ff <= pos ? start_ff : end_ff;
         prod_ff    <= PROD_W'(courant_ff) * PROD_W'(diff);
         base_ff    <= pos ? rd_ff : prev_ff;
         if (s2_valid_ff) begin
            rsp_payload_ff.cell_index <= s2_idx_ff[3:0];
            rsp_payload_ff.cell_value <= new_value;
            rsp_payload_ff.last_cell  <= s2_last_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff  <= cmd.issue;
         s2_valid_ff  <= s1_valid_ff && s1_emit_ff;
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

`default_nettype wire

FILE: sv/upwind_advection_step_unit.sv
// First-order upwind advection over a line of up to 16 cells.
// Input channel (req_valid / req_stall / req_payload): one item is one time
// step, carrying the signed Q1.15 Courant number and both inflow values.
// Result channel (rsp_valid / rsp_stall / rsp_payload): the step's updated
// cells come out in index order, one item per cell, last_cell set on the final
// one. Each step reads the values the previous step left in the cell memory.
// Pipeline: the memory is read once per cell plus one extra slot, through a read
// register, a multiply register and the output register. With flow that is not
// positive the first slot gives no result, which delays the first result.
// One step is in flight at a time; req_stall stays high until its last cell
// has been written back.
// A stalled result holds the whole pipeline in place, so the step simply
// stretches for as long as the stall lasts.
// Reset clears the cell memory to zero (per-entry valid flags) and sets
// cells_in_use to 16; no clearing pass is needed. cells_in_use (byte address 0
// on the csr port) is written only while idle, a rule kept by the user alone.
`default_nettype none

module upwind_advection_step_unit
   import uas_pkg::*;
#(
   parameter int MAX_CELLS = MAX_CELLS_DEF
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire req_payload_type       req_payload,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output rsp_payload_type            rsp_payload,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0]      csr_prdata,
   output logic                       csr_pready
);

   localparam int LINE_LIMIT = (MAX_CELLS > RESULT_CAP) ? RESULT_CAP : MAX_CELLS;

   logic [CELLS_W-1:0] cells_in_use_ff;
   logic [SLOT_W-1:0]  n_cells;
   logic               csr_hit;
   cmd_type            cmd;
   stat_type           stat;

   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[2] == REG_CELLS_IN_USE);

   always_ff @(posedge clock) begin
      if (reset) begin
         cells_in_use_ff <= CELLS_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit) begin
         cells_in_use_ff <= csr_pwdata[CELLS_W-1:0];
      end
   end

   assign csr_prdata = csr_hit ? CSR_DATA_W'(cells_in_use_ff) : '0;

   // clamp the cell count into 2 .. line limit
   always_comb begin
      if (cells_in_use_ff < CELLS_W'(CELLS_MIN)) begin
         n_cells = SLOT_W'(CELLS_MIN);
      end else if (cells_in_use_ff > CELLS_W'(LINE_LIMIT)) begin
         n_cells = SLOT_W'(LINE_LIMIT);
      end else begin
         n_cells = cells_in_use_ff;
      end
   end

   uas_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .n_cells   (n_cells),
      .stat      (stat),
      .cmd       (cmd)
   );

   uas_dpath #(
      .MAX_CELLS (MAX_CELLS)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("block took an item but did not go busy");

   a_no_accept_mid_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_payload.last_cell) |-> req_stall)
      else $error("block ready for a new item before the step finished");

   a_index_in_line: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_payload.cell_index) < LINE_LIMIT))
      else $error("cell index beyond the line");

   a_last_not_first: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.last_cell) |-> (rsp_payload.cell_index != 4'd0))
      else $error("step ended on cell 0");

endmodule

`default_nettype wire

FILE: sim/advection_step_checker.sv
`timescale 1ns / 1ps

module advection_step_checker
   import uas_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_stall,
   input  wire req_payload_type       req_payload,
   input  wire logic                  rsp_valid,
   input  wire logic                  rsp_stall,
   input  wire rsp_payload_type       rsp_payload,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic                  csr_pready,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output int                         mismatch_count,
   output int                         cells_pending
);

   localparam logic [CSR_ADDR_W-1:0] CELLS_ADDR = CSR_ADDR_W'(REG_CELLS_IN_USE) << 2;
   localparam int REPORT_LINES = 100;

   logic [15:0]        cell_mem [RESULT_CAP];
   logic [CELLS_W-1:0] cells_cfg;
   rsp_payload_type    expected_cells [$];

   // old - round(c * diff / 2^15), ties toward +inf, clamped to Q0.16
   function automatic logic [15:0] advect_cell(logic signed [15:0] c, logic [15:0] old,
                                               int diff);
      longint prod;
      longint term;
      longint r;
      prod = longint'(c) * longint'(diff);
      term = (prod + ROUND_HALF) >>> FRAC_BITS;
      r = longint'(old) - term;
      if (r < 0) r = 0;
      if (r > 65535) r = 65535;
      return r[15:0];
   endfunction

   function automatic int used_cells(logic [CELLS_W-1:0] cfg);
      int n;
      int lim;
      lim = (MAX_CELLS_DEF < RESULT_CAP) ? MAX_CELLS_DEF : RESULT_CAP;
      n = int'(cfg);
      if (n < CELLS_MIN) n = CELLS_MIN;
      if (n > lim) n = lim;
      return n;
   endfunction

   task automatic predict_step(req_payload_type item);
      logic [15:0]     old [RESULT_CAP];
      logic [15:0]     nw [RESULT_CAP];
      int              n;
      rsp_payload_type e;
      old = cell_mem;
      nw = cell_mem;
      n = used_cells(cells_cfg);
      if ($signed(item.courant) > 0) begin
         nw[0] = item.start_value;
         for (int i = 1; i < n; i++)
            nw[i] = advect_cell(item.courant, old[i], int'(old[i]) - int'(old[i-1]));
      end else begin
         for (int i = 0; i + 1 < n; i++)
            nw[i] = advect_cell(item.courant, old[i], int'(old[i+1]) - int'(old[i]));
         nw[n-1] = item.end_value;
      end
      for (int i = 0; i < n; i++) begin
         cell_mem[i] = nw[i];
         e.cell_index = i[3:0];
         e.cell_value = nw[i];
         e.last_cell = (i == n - 1);
         expected_cells.push_back(e);
      end
   endtask

   task automatic report_mismatch(string msg);
      mismatch_count++;
      if (mismatch_count <= REPORT_LINES)
         $display("%0t ns: result mismatch: %s", $time, msg);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < RESULT_CAP; i++)
            cell_mem[i] = '0;
         cells_cfg = CELLS_RESET;
         expected_cells.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_paddr == CELLS_ADDR)
            cells_cfg = csr_pwdata[CELLS_W-1:0];
         if (req_valid && !req_stall)
            predict_step(req_payload);
         if (rsp_valid && !rsp_stall) begin
            if (expected_cells.size() == 0) begin
               report_mismatch($sformatf("unexpected item idx=%0d value=%h last=%b",
                                         rsp_payload.cell_index, rsp_payload.cell_value,
                                         rsp_payload.last_cell));
            end else begin
               rsp_payload_type e;
               e = expected_cells.pop_front();
               if (rsp_payload.cell_index !== e.cell_index)
                  report_mismatch($sformatf("cell_index got %0d want %0d",
                                            rsp_payload.cell_index, e.cell_index));
               if (rsp_payload.cell_value !== e.cell_value)
                  report_mismatch($sformatf("cell %0d cell_value got %h want %h",
                                            e.cell_index, rsp_payload.cell_value,
                                            e.cell_value));
               if (rsp_payload.last_cell !== e.last_cell)
                  report_mismatch($sformatf("cell %0d last_cell got %b want %b",
                                            e.cell_index, rsp_payload.last_cell,
                                            e.last_cell));
            end
         end
      end
      cells_pending = expected_cells.size();
   end

endmodule

FILE: sim/upwind_advection_step_unit_test.sv
`timescale 1ns / 1ps

module upwind_advection_step_unit_test;
   import uas_pkg::*;

   localparam logic [CSR_ADDR_W-1:0] CELLS_ADDR = CSR_ADDR_W'(REG_CELLS_IN_USE) << 2;
   // first address past the register list; writes there must be ignored
   localparam logic [CSR_ADDR_W-1:0] SPARE_ADDR = CSR_ADDR_W'(REG_CELLS_IN_USE + 1) << 2;
   localparam int IDLE_LIMIT   = 4000;
   localparam int RAND_PHASES  = 8;
   localparam int PHASE_ITEMS  = 50;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_payload_type       req_payload = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_payload_type       rsp_payload;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int mismatch_count;
   int cells_pending;
   int burst_left;
   int idle_cycles = 0;
   int stall_mode = 0;
   int stall_span = 0;
   int stall_phase = 0;

   upwind_advection_step_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   advection_step_checker u_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_payload    (rsp_payload),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_pready     (csr_pready),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .mismatch_count (mismatch_count),
      .cells_pending  (cells_pending)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // receiver stall pattern: switch between free-running, light, heavy and periodic
   always @(negedge clock) begin
      if (stall_span == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_span = $urandom_range(20, 200);
      end
      stall_span--;
      stall_phase++;
      case (stall_mode)
         0: rsp_stall = 1'b0;
         1: rsp_stall = ($urandom_range(0, 3) == 0);
         2: rsp_stall = ($urandom_range(0, 9) < 7);
         default: rsp_stall = (stall_phase % 3 == 0);
      endcase
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_psel && csr_penable))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("** upwind_advection_step_unit: FAILED **");
         $finish;
      end
   end

   function automatic logic [15:0] pick_courant();
      case ($urandom_range(0, 7))
         0: return 16'h0000;
         1: return 16'h7FFF;
         2: return 16'h8000;
         3: return 16'($urandom_range(1, 255));
         4: return -16'($urandom_range(1, 255));
         5: return {1'b0, 15'($urandom())};
         6: return {1'b1, 15'($urandom())};
         default: return 16'($urandom());
      endcase
   endfunction

   function automatic logic [15:0] pick_value();
      case ($urandom_range(0, 7))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom());
      endcase
   endfunction

   // hold valid through a burst; drop it for a random gap when the burst ends
   task automatic send_step(logic [15:0] c, logic [15:0] sv, logic [15:0] ev);
      @(negedge clock);
      req_valid = 1'b1;
      req_payload.courant = c;
      req_payload.start_value = sv;
      req_payload.end_value = ev;
      do @(posedge clock); while (req_stall);
      burst_left--;
      if (burst_left <= 0) begin
         @(negedge clock);
         req_valid = 1'b0;
         repeat ($urandom_range(0, 15)) @(negedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                  : $urandom_range(1, 12);
      end
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (cells_pending != 0) @(negedge clock);
      repeat (6) @(negedge clock);
   endtask

   task automatic csr_write(logic [CSR_ADDR_W-1:0] addr, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_psel = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite = 1'b1;
      csr_paddr = addr;
      csr_pwdata = data;
      @(negedge clock);
      csr_penable = 1'b1;
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
   endtask

   task automatic set_cells(logic [CSR_ADDR_W-1:0] addr, logic [CELLS_W-1:0] count);
      wait_drained();
      // junk in the upper bits must not matter
      csr_write(addr, {(CSR_DATA_W - CELLS_W)'($urandom()), count});
   endtask

   initial begin
      int count;
      burst_left = $urandom_range(1, 12);
      repeat (11) @(negedge clock);
      reset = 1'b0;

      // full line from the cleared store
      send_step(16'h7FFF, 16'hFFFF, 16'h0000);
      send_step(16'h7FFF, 16'h0000, 16'hFFFF);
      send_step(16'h4000, 16'h8000, 16'h0000);
      send_step(16'h0001, 16'hFFFF, 16'h0000);
      send_step(16'h8000, 16'h0000, 16'hFFFF);
      send_step(16'hFFFF, 16'hFFFF, 16'h0000);
      send_step(16'h0000, 16'h0000, 16'h1234);
      send_step(16'hC000, 16'h5555, 16'h0000);
      send_step(16'h7FFF, 16'hFFFF, 16'hAAAA);
      send_step(16'h0000, 16'hFFFF, 16'hFFFF);

      // smallest line, counts below the minimum, above the limit, and a write past the list
      set_cells(CELLS_ADDR, 5'd2);
      send_step(16'h7FFF, 16'hFFFF, 16'h0000);
      send_step(16'h8000, 16'h0000, 16'h0000);
      set_cells(CELLS_ADDR, 5'd0);
      send_step(16'h2000, 16'h1111, 16'hEEEE);
      send_step(16'h0000, 16'h0000, 16'h7777);
      set_cells(CELLS_ADDR, 5'd1);
      send_step(16'hE000, 16'h0000, 16'hFFFF);
      set_cells(CELLS_ADDR, 5'd31);
      send_step(16'h6000, 16'hFFFF, 16'h0000);
      send_step(16'hA000, 16'h0000, 16'h8001);
      set_cells(CELLS_ADDR, 5'd17);
      send_step(16'h0000, 16'h0000, 16'h0000);
      set_cells(CELLS_ADDR, 5'd5);
      set_cells(SPARE_ADDR, 5'd3);
      send_step(16'h3000, 16'hFFFF, 16'h0000);
      send_step(16'hD000, 16'h0000, 16'hFFFF);

      for (int p = 0; p < RAND_PHASES; p++) begin
         case ($urandom_range(0, 5))
            0: count = $urandom_range(0, 1);
            1: count = $urandom_range(17, 31);
            2: count = 16;
            default: count = $urandom_range(2, 16);
         endcase
         set_cells(CELLS_ADDR, count[CELLS_W-1:0]);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            // let the block run dry once in a while
            if (k == PHASE_ITEMS / 2 && p % 2 == 0)
               wait_drained();
            send_step(pick_courant(), pick_value(), pick_value());
         end
      end

      wait_drained();
      repeat (40) @(posedge clock);
      if (mismatch_count == 0 && cells_pending == 0)
         $display("** upwind_advection_step_unit: PASSED **");
      else
         $display("** upwind_advection_step_unit: FAILED **");
      $finish;
   end

endmodule

FILE: filelist.f
sv/uas_pkg.sv
sv/uas_ctrl.sv
sv/uas_dpath.sv
sv/upwind_advection_step_unit.sv
sim/advection_step_checker.sv
sim/upwind_advection_step_unit_test.sv
